>>> src/bmcs_pkg.sv
// Shared types and constants for the button menu and clock-set controller.
// Used by every module under src; no dependencies.
package bmcs_pkg;

    localparam int MENU_ENTRIES_DEF = 5;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int BLINK_W = 10;

    localparam logic             REG_BLINK_PERIOD = 1'b0;
    localparam logic [BLINK_W-1:0] BLINK_RESET    = 10'd50;

    localparam logic [4:0] HOUR12_MAX  = 5'd12;
    localparam logic [4:0] HOUR24_MAX  = 5'd23;
    localparam logic [5:0] MINSEC_MAX  = 6'd59;
    localparam logic [4:0] DAY_MAX     = 5'd31;
    localparam logic [3:0] MONTH_MAX   = 4'd12;
    localparam logic [6:0] YEAR_MAX    = 7'd99;
    localparam logic [5:0] SECOND_NONE = 6'd60;

    localparam logic [2:0] FIELD_HOUR   = 3'd0;
    localparam logic [2:0] FIELD_MINUTE = 3'd1;
    localparam logic [2:0] FIELD_SECOND = 3'd2;
    localparam logic [2:0] FIELD_AMPM   = 3'd3;
    localparam logic [2:0] FIELD_DAY    = 3'd4;
    localparam logic [2:0] FIELD_MONTH  = 3'd5;
    localparam logic [2:0] FIELD_YEAR   = 3'd6;
    localparam logic [2:0] FIELD_DONE   = 3'd7;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_K1   = 2'd1,
        KIND_K2   = 2'd2,
        KIND_BOTH = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        MODE_BOOT   = 4'd0,
        MODE_HOME   = 4'd1,
        MODE_MENU   = 4'd2,
        MODE_PAGE0  = 4'd3,
        MODE_PAGE1  = 4'd4,
        MODE_PAGE2  = 4'd5,
        MODE_TIME   = 4'd6,
        MODE_FORMAT = 4'd7,
        MODE_EDIT   = 4'd8,
        MODE_SAVE   = 4'd9
    } t_mode;

    typedef struct packed {
        logic       twelve;
        logic       pm;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
    } t_clock;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
    } t_date;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [5:0] now_second;
        logic       now_pm;
        logic       now_twelve_hour;
        logic [4:0] now_day;
        logic [3:0] now_month;
        logic [6:0] now_year;
    } t_request;

    typedef struct packed {
        logic [3:0]  ui_mode;
        logic [2:0]  menu_pos;
        logic [2:0]  field_sel;
        logic        blink_on;
        logic        format_pick;
        logic        save_pick;
        logic        redraw;
        logic        write_clock;
        logic [18:0] edit_clock_word;
        logic [15:0] edit_date_word;
    } t_result;

    typedef struct packed {
        logic       load;
        logic       convert;
        logic       to_twelve;
        logic       step;
        logic       up;
        logic [2:0] field;
    } t_edit_ctl;

endpackage

>>> src/bmcs_edit.sv
// Edit-copy datapath: load from live clock, 12/24-hour conversion, field step.
// Depends on bmcs_pkg.
module bmcs_edit
    import bmcs_pkg::*;
(
    input  t_clock    i_clock,
    input  t_date     i_date,
    input  t_edit_ctl i_ctl,
    input  t_request  i_req,
    output t_clock    o_clock,
    output t_date     o_date
);

    logic [5:0] hour_inc;
    logic [6:0] min_inc;
    logic [6:0] sec_inc;
    logic [5:0] day_inc;
    logic [4:0] month_inc;
    logic [7:0] year_inc;

    assign hour_inc  = {1'b0, i_clock.hour} + 6'd1;
    assign min_inc   = {1'b0, i_clock.minute} + 7'd1;
    assign sec_inc   = {1'b0, i_clock.second} + 7'd1;
    assign day_inc   = {1'b0, i_date.day} + 6'd1;
    assign month_inc = {1'b0, i_date.month} + 5'd1;
    assign year_inc  = {1'b0, i_date.year} + 8'd1;

    always_comb begin
        o_clock = i_clock;
        o_date  = i_date;
        if (i_ctl.load) begin
            o_clock.hour   = i_req.now_hour;
            o_clock.minute = i_req.now_minute;
            o_clock.second = i_req.now_second;
            o_clock.pm     = i_req.now_pm;
            o_clock.twelve = i_req.now_twelve_hour;
            o_date.day     = i_req.now_day;
            o_date.month   = i_req.now_month;
            o_date.year    = i_req.now_year;
        end else if (i_ctl.convert) begin
            if (i_ctl.to_twelve) begin
                if (i_clock.hour == 5'd0) begin
                    o_clock.hour = HOUR12_MAX;
                    o_clock.pm   = 1'b0;
                end else if (i_clock.hour == HOUR12_MAX) begin
                    o_clock.pm = 1'b1;
                end else if (i_clock.hour > HOUR12_MAX) begin
                    o_clock.hour = i_clock.hour - HOUR12_MAX;
                    o_clock.pm   = 1'b1;
                end else begin
                    o_clock.pm = 1'b0;
                end
            end else begin
                if (i_clock.pm && i_clock.hour < HOUR12_MAX) begin
                    o_clock.hour = i_clock.hour + HOUR12_MAX;
                end
                if (!i_clock.pm && i_clock.hour == HOUR12_MAX) begin
                    o_clock.hour = 5'd0;
                end
                o_clock.pm = 1'b0;
            end
            o_clock.twelve = i_ctl.to_twelve;
        end else if (i_ctl.step) begin
            case (i_ctl.field)
                FIELD_HOUR: begin
                    if (i_clock.twelve) begin
                        if (i_ctl.up) begin
                            o_clock.hour = (hour_inc > {1'b0, HOUR12_MAX}) ? 5'd1
                                                                          : hour_inc[4:0];
                        end else begin
                            o_clock.hour = (i_clock.hour <= 5'd1) ? HOUR12_MAX
                                                                 : i_clock.hour - 5'd1;
                        end
                    end else begin
                        if (i_ctl.up) begin
                            o_clock.hour = (hour_inc > {1'b0, HOUR24_MAX}) ? 5'd0
                                                                          : hour_inc[4:0];
                        end else begin
                            o_clock.hour = (i_clock.hour == 5'd0) ? HOUR24_MAX
                                                                 : i_clock.hour - 5'd1;
                        end
                    end
                end
                FIELD_MINUTE: begin
                    if (i_ctl.up) begin
                        o_clock.minute = (min_inc > {1'b0, MINSEC_MAX}) ? 6'd0 : min_inc[5:0];
                    end else begin
                        o_clock.minute = (i_clock.minute == 6'd0) ? MINSEC_MAX
                                                                 : i_clock.minute - 6'd1;
                    end
                end
                FIELD_SECOND: begin
                    if (i_ctl.up) begin
                        o_clock.second = (sec_inc > {1'b0, MINSEC_MAX}) ? 6'd0 : sec_inc[5:0];
                    end else begin
                        o_clock.second = (i_clock.second == 6'd0) ? MINSEC_MAX
                                                                 : i_clock.second - 6'd1;
                    end
                end
                FIELD_AMPM: begin
                    o_clock.pm = ~i_clock.pm;
                end
                FIELD_DAY: begin
                    if (i_ctl.up) begin
                        o_date.day = (day_inc > {1'b0, DAY_MAX}) ? 5'd1 : day_inc[4:0];
                    end else begin
                        o_date.day = (i_date.day <= 5'd1) ? DAY_MAX : i_date.day - 5'd1;
                    end
                end
                FIELD_MONTH: begin
                    if (i_ctl.up) begin
                        o_date.month = (month_inc > {1'b0, MONTH_MAX}) ? 4'd1 : month_inc[3:0];
                    end else begin
                        o_date.month = (i_date.month <= 4'd1) ? MONTH_MAX
                                                             : i_date.month - 4'd1;
                    end
                end
                FIELD_YEAR: begin
                    if (i_ctl.up) begin
                        o_date.year = (year_inc > {1'b0, YEAR_MAX}) ? 7'd0 : year_inc[6:0];
                    end else begin
                        o_date.year = (i_date.year == 7'd0) ? YEAR_MAX : i_date.year - 7'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> src/bmcs_ctrl.sv
// UI mode state machine with menu, field, choice, blink and edit-copy registers.
// Depends on bmcs_pkg and bmcs_edit.
module bmcs_ctrl
    import bmcs_pkg::*;
#(
    parameter int MENU_ENTRIES = MENU_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  t_request           i_req,
    input  logic [BLINK_W-1:0] i_blink_period,
    output t_result            o_res
);

    localparam logic [3:0] MENU_N    = 4'(MENU_ENTRIES);
    localparam logic [2:0] MENU_LAST = 3'(MENU_ENTRIES - 1);

    t_mode              r_mode, n_mode;
    logic [2:0]         r_menu, n_menu;
    logic [2:0]         r_field, n_field;
    logic               r_format, n_format;
    logic               r_save, n_save;
    logic               r_blink, n_blink;
    logic [BLINK_W-1:0] r_blink_cnt, n_blink_cnt;
    logic [5:0]         r_seen_sec, n_seen_sec;
    t_clock             r_clock, n_clock;
    t_date              r_date, n_date;

    t_kind              kind;
    t_edit_ctl          edit_ctl;
    logic               redraw;
    logic               write_clock;
    logic [3:0]         menu_inc;
    logic               menu_exit;
    logic [2:0]         fld_inc;
    logic [2:0]         fld_skip;
    logic               fld_done;
    logic [BLINK_W-1:0] blink_inc;
    logic               sec_changed;

    assign kind        = t_kind'(i_req.kind);
    assign menu_inc    = {1'b0, r_menu} + 4'd1;
    assign menu_exit   = ({1'b0, r_menu} >= MENU_N - 4'd1);
    assign fld_inc     = r_field + 3'd1;
    assign fld_skip    = (!r_clock.twelve && fld_inc == FIELD_AMPM) ? FIELD_DAY : fld_inc;
    assign fld_done    = (fld_skip == FIELD_DONE) || (fld_skip == FIELD_HOUR);
    assign blink_inc   = r_blink_cnt + BLINK_W'(1);
    assign sec_changed = (i_req.now_second != r_seen_sec);

    // next mode
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_BOOT: n_mode = MODE_HOME;
            MODE_HOME: begin
                if (kind == KIND_BOTH) n_mode = MODE_MENU;
            end
            MODE_MENU: begin
                if (kind == KIND_BOTH) begin
                    if (menu_exit) begin
                        n_mode = MODE_HOME;
                    end else begin
                        case (r_menu)
                            3'd0:    n_mode = MODE_PAGE0;
                            3'd1:    n_mode = MODE_PAGE1;
                            3'd2:    n_mode = MODE_PAGE2;
                            3'd3:    n_mode = MODE_TIME;
                            default: n_mode = MODE_MENU;
                        endcase
                    end
                end
            end
            MODE_PAGE0, MODE_PAGE1, MODE_PAGE2: begin
                if (kind == KIND_BOTH) n_mode = MODE_MENU;
            end
            MODE_TIME: begin
                case (kind) inside
                    KIND_BOTH:        n_mode = MODE_FORMAT;
                    KIND_K1, KIND_K2: n_mode = MODE_MENU;
                    default:          n_mode = MODE_TIME;
                endcase
            end
            MODE_FORMAT: begin
                if (kind == KIND_BOTH) n_mode = MODE_EDIT;
            end
            MODE_EDIT: begin
                if (kind == KIND_BOTH && fld_done) n_mode = MODE_SAVE;
            end
            MODE_SAVE: begin
                if (kind == KIND_BOTH) n_mode = MODE_TIME;
            end
            default: n_mode = MODE_HOME;
        endcase
    end

    // register updates and strobes
    always_comb begin
        n_menu      = r_menu;
        n_field     = r_field;
        n_format    = r_format;
        n_save      = r_save;
        n_blink     = r_blink;
        n_blink_cnt = r_blink_cnt;
        n_seen_sec  = r_seen_sec;
        redraw      = 1'b0;
        write_clock = 1'b0;
        edit_ctl    = '0;
        edit_ctl.field     = r_field;
        edit_ctl.up        = (kind == KIND_K1);
        edit_ctl.to_twelve = r_format;
        unique case (r_mode)
            MODE_HOME: begin
                if (kind == KIND_BOTH) begin
                    redraw = 1'b1;
                end else if (sec_changed) begin
                    n_seen_sec = i_req.now_second;
                    redraw     = 1'b1;
                end
            end
            MODE_MENU: begin
                case (kind)
                    KIND_K1: begin
                        n_menu = (menu_inc >= MENU_N) ? 3'd0 : menu_inc[2:0];
                        redraw = 1'b1;
                    end
                    KIND_K2: begin
                        n_menu = (r_menu == 3'd0 || {1'b0, r_menu} >= MENU_N) ? MENU_LAST
                                                                           : r_menu - 3'd1;
                        redraw = 1'b1;
                    end
                    KIND_BOTH: begin
                        if (menu_exit) n_menu = 3'd0;
                        redraw = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            MODE_PAGE0, MODE_PAGE1, MODE_PAGE2: begin
                if (kind == KIND_BOTH) redraw = 1'b1;
            end
            MODE_TIME: begin
                case (kind) inside
                    KIND_BOTH: begin
                        edit_ctl.load = 1'b1;
                        n_format      = i_req.now_twelve_hour;
                        redraw        = 1'b1;
                    end
                    KIND_K1, KIND_K2: redraw = 1'b1;
                    default: begin
                    end
                endcase
                if (sec_changed) begin
                    n_seen_sec = i_req.now_second;
                    redraw     = 1'b1;
                end
            end
            MODE_FORMAT: begin
                case (kind) inside
                    KIND_K1, KIND_K2: begin
                        n_format = ~r_format;
                        redraw   = 1'b1;
                    end
                    KIND_BOTH: begin
                        edit_ctl.convert = (r_format != r_clock.twelve);
                        n_field          = FIELD_HOUR;
                        redraw           = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            MODE_EDIT: begin
                case (kind) inside
                    KIND_BOTH: begin
                        if (fld_done) begin
                            n_field = FIELD_DONE;
                            n_save  = 1'b1;
                        end else begin
                            n_field = fld_skip;
                        end
                        redraw = 1'b1;
                    end
                    KIND_K1, KIND_K2: begin
                        edit_ctl.step = 1'b1;
                        redraw        = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (blink_inc >= i_blink_period) begin
                    n_blink_cnt = '0;
                    n_blink     = ~r_blink;
                    redraw      = 1'b1;
                end else begin
                    n_blink_cnt = blink_inc;
                end
            end
            MODE_SAVE: begin
                case (kind) inside
                    KIND_K1, KIND_K2: begin
                        n_save = ~r_save;
                        redraw = 1'b1;
                    end
                    KIND_BOTH: begin
                        write_clock = r_save;
                        redraw      = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: redraw = 1'b1;
        endcase
    end

    bmcs_edit u_edit (
        .i_clock (r_clock),
        .i_date  (r_date),
        .i_ctl   (edit_ctl),
        .i_req   (i_req),
        .o_clock (n_clock),
        .o_date  (n_date)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_BOOT;
            r_menu      <= 3'd0;
            r_field     <= FIELD_HOUR;
            r_format    <= 1'b0;
            r_save      <= 1'b1;
            r_blink     <= 1'b1;
            r_blink_cnt <= '0;
            r_seen_sec  <= SECOND_NONE;
            r_clock     <= '0;
            r_date      <= '0;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_menu      <= n_menu;
            r_field     <= n_field;
            r_format    <= n_format;
            r_save      <= n_save;
            r_blink     <= n_blink;
            r_blink_cnt <= n_blink_cnt;
            r_seen_sec  <= n_seen_sec;
            r_clock     <= n_clock;
            r_date      <= n_date;
        end
    end

    always_comb begin
        o_res.ui_mode         = n_mode;
        o_res.menu_pos        = n_menu;
        o_res.field_sel       = n_field;
        o_res.blink_on        = n_blink;
        o_res.format_pick     = n_format;
        o_res.save_pick       = n_save;
        o_res.redraw          = redraw;
        o_res.write_clock     = write_clock;
        o_res.edit_clock_word = n_clock;
        o_res.edit_date_word  = n_date;
    end

endmodule

>>> src/button_menu_clock_set_fsm.sv
// Button menu and clock-set controller: request and result registers, APB
// blink-period register. Depends on bmcs_pkg and bmcs_ctrl.
//
// One button poll per request, one result per request. Requests are taken in
// every clock cycle while the result side keeps up; a result passes through the
// request register, then one next-state pass into the result register. A
// stalled result holds the pipe; the request register still takes one more
// poll only if it is empty. The blink period is written through the APB port
// at byte addresses 0 to 3 (paddr[2] low) and reads back there; there is no
// clearing pass after reset.
module button_menu_clock_set_fsm
    import bmcs_pkg::*;
#(
    parameter int MENU_ENTRIES = MENU_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  t_request          i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic               r_in_valid;
    t_request           r_in;
    logic               r_out_valid;
    t_result            r_out;
    logic [BLINK_W-1:0] r_blink_period;
    logic               advance;
    logic               reg_sel;
    t_result            step_res;

    assign advance     = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_req_ready = !r_in_valid || advance;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1] == REG_BLINK_PERIOD);
    assign prdata  = reg_sel ? {{(APB_DW-BLINK_W){1'b0}}, r_blink_period} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_period <= BLINK_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_blink_period <= pwdata[BLINK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_req_ready) begin
            r_in_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_in <= i_req;
        end
    end

    bmcs_ctrl #(
        .MENU_ENTRIES (MENU_ENTRIES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_req          (r_in),
        .i_blink_period (r_blink_period),
        .o_res          (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    a_write_in_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.write_clock |-> o_res.ui_mode == MODE_TIME && o_res.save_pick)
        else $error("write strobe outside a save that returns to the time view");

    a_save_field_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.ui_mode == MODE_SAVE |-> o_res.field_sel == FIELD_DONE)
        else $error("save prompt without finished field walk");

    a_held_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("held request lost or changed");

    a_result_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_res_valid)
        else $error("processed request produced no result");

endmodule
